>>> design/qsa_pkg.sv
package qsa_pkg;

    // Default sizes
    localparam int DEF_FAMILIES = 4;
    localparam int DEF_SLOTS    = 64;

    // Fixed register layout: three caps bits and seven count bits per family
    localparam int REG_FAMILIES   = 4;
    localparam int CAPS_BITS      = 3;
    localparam int COUNT_BITS     = 7;
    localparam int FAMILY_COUNT_W = 3;
    localparam int CAPS_W         = 12;
    localparam int COUNTS_W       = 28;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 28;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FAMILY_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAMILY_CAPS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_COUNTS = 2'd2;

    // Request codes
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [1:0] KIND_COPY     = 2'd0;
    localparam logic [1:0] KIND_COMPUTE  = 2'd1;
    localparam logic [1:0] KIND_GRAPHICS = 2'd2;

    localparam logic [1:0] PRIO_NORMAL   = 2'd0;
    localparam logic [1:0] PRIO_HIGH     = 2'd1;
    localparam logic [1:0] PRIO_REALTIME = 2'd2;

    // Capability bits
    localparam logic [CAPS_BITS-1:0] CAP_GRAPHICS = 3'b001;
    localparam logic [CAPS_BITS-1:0] CAP_COMPUTE  = 3'b010;
    localparam logic [CAPS_BITS-1:0] CAP_TRANSFER = 3'b100;

    // Result status
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_BAD_SLOT  = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [1:0] queue_kind;
        logic [1:0] wanted_priority;
        logic [1:0] release_family;
        logic [5:0] release_slot;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] granted_family;
        logic [5:0] granted_slot;
    } result_t;

endpackage

>>> design/qsa_ram.sv
module qsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/qsa_match.sv
// Finds the lowest free slot of one family whose priority matches.
module qsa_match #(
    parameter int SLOTS = 64,
    localparam int CW = $clog2(SLOTS + 1),
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic [SLOTS-1:0] free_word,
    input  logic [CW-1:0]    count,
    input  logic [1:0]       prio,
    input  logic             eligible,
    output logic             found,
    output logic [SW-1:0]    slot
);

    logic [SLOTS-1:0] hit;
    logic [CW-1:0]    half;

    assign half = count >> 1;

    always_comb
    begin
        logic [1:0] p;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (count == CW'(1))
            begin
                p = qsa_pkg::PRIO_NORMAL;
            end
            else if (count == CW'(2))
            begin
                p = (s == 0) ? qsa_pkg::PRIO_NORMAL : qsa_pkg::PRIO_HIGH;
            end
            else if (s == int'(count) - 1)
            begin
                p = qsa_pkg::PRIO_REALTIME;
            end
            else if (s < int'(half))
            begin
                p = qsa_pkg::PRIO_NORMAL;
            end
            else
            begin
                p = qsa_pkg::PRIO_HIGH;
            end
            hit[s] = eligible && free_word[s] && (s < int'(count)) && (p == prio);
        end
    end

    always_comb
    begin
        slot = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (hit[s])
            begin
                slot = SW'(s);
            end
        end
    end

    assign found = |hit;

endmodule

>>> design/queue_slot_allocator.sv
// Queue slot allocator. One request per start; busy stays high until its
// result has been produced. The result appears on result for exactly one
// cycle with done high and must be taken then. The free map sits in a
// one-read, one-write RAM of one word per family, so an acquire examines one
// family per cycle, and a new start can be taken at the edge that ends the
// result cycle. An in-range release reads the word, then writes it back in
// S_REL, which also registers its result. A request settled from configuration
// alone (no families, unknown kind, release out of range) gives its result
// the next cycle and a new start may follow at once. No clearing pass after
// reset: per-family valid bits make an unwritten word read as all free.
module queue_slot_allocator #(
    parameter int FAMILIES         = qsa_pkg::DEF_FAMILIES,
    parameter int SLOTS_PER_FAMILY = qsa_pkg::DEF_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  qsa_pkg::req_t                      req,
    output logic                               done,
    output qsa_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [qsa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int FW  = (FAMILIES > 1) ? $clog2(FAMILIES) : 1;
    localparam int NFW = $clog2(FAMILIES + 1);
    localparam int CW  = $clog2(SLOTS_PER_FAMILY + 1);
    localparam int SW  = (SLOTS_PER_FAMILY > 1) ? $clog2(SLOTS_PER_FAMILY) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REL
    } state_t;

    state_t state_reg, state_next;

    logic [qsa_pkg::FAMILY_COUNT_W-1:0] family_count_reg;
    logic [qsa_pkg::CAPS_W-1:0]         family_caps_reg;
    logic [qsa_pkg::COUNTS_W-1:0]       queue_counts_reg;

    logic             done_reg, done_next;
    qsa_pkg::result_t result_reg, result_next;
    logic [FW-1:0]    cur_f_reg, cur_f_next;
    logic [1:0]       kind_reg, kind_next;
    logic [1:0]       prio_reg, prio_next;
    logic [SW-1:0]    rel_slot_reg, rel_slot_next;
    logic [FAMILIES-1:0] valid_reg;
    logic             rd_valid_reg;

    logic                        rd_en, wr_en;
    logic [FW-1:0]               rd_addr, wr_addr;
    logic [SLOTS_PER_FAMILY-1:0] rd_data, wr_data, word, one_hot;

    logic [NFW-1:0] nf;
    logic [FW-1:0]  start_f;
    logic [CW-1:0]  rel_count, cur_count;
    logic           rel_ok, eligible, found;
    logic [SW-1:0]  slot;

    function automatic logic [CW-1:0] count_of(input int f);
        logic [qsa_pkg::COUNT_BITS-1:0] raw;
        raw = '0;
        for (int i = 0; i < qsa_pkg::REG_FAMILIES; i++)
        begin
            if (f == i)
            begin
                raw = queue_counts_reg[qsa_pkg::COUNT_BITS*i +: qsa_pkg::COUNT_BITS];
            end
        end
        if (int'(raw) > SLOTS_PER_FAMILY)
        begin
            return CW'(SLOTS_PER_FAMILY);
        end
        return CW'(raw);
    endfunction

    function automatic logic [qsa_pkg::CAPS_BITS-1:0] caps_of(input int f);
        logic [qsa_pkg::CAPS_BITS-1:0] c;
        c = '0;
        for (int i = 0; i < qsa_pkg::REG_FAMILIES; i++)
        begin
            if (f == i)
            begin
                c = family_caps_reg[qsa_pkg::CAPS_BITS*i +: qsa_pkg::CAPS_BITS];
            end
        end
        return c;
    endfunction

    function automatic logic [qsa_pkg::CAPS_BITS-1:0] need_of(input logic [1:0] kind);
        case (kind)
            qsa_pkg::KIND_COPY:     return qsa_pkg::CAP_TRANSFER;
            qsa_pkg::KIND_COMPUTE:  return qsa_pkg::CAP_COMPUTE;
            qsa_pkg::KIND_GRAPHICS: return qsa_pkg::CAP_GRAPHICS;
            default:                return '0;
        endcase
    endfunction

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_count_reg <= '0;
            family_caps_reg  <= '0;
            queue_counts_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qsa_pkg::CFG_FAMILY_COUNT:
                    family_count_reg <= cfg_data[qsa_pkg::FAMILY_COUNT_W-1:0];
                qsa_pkg::CFG_FAMILY_CAPS:
                    family_caps_reg <= cfg_data[qsa_pkg::CAPS_W-1:0];
                qsa_pkg::CFG_QUEUE_COUNTS:
                    queue_counts_reg <= cfg_data[qsa_pkg::COUNTS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign nf = (int'(family_count_reg) > FAMILIES) ? NFW'(FAMILIES) : NFW'(family_count_reg);
    assign start_f = FW'(nf - NFW'(1));

    // functions read the config registers directly
    always_comb
    begin
        rel_count = count_of(int'(req.release_family));
        rel_ok    = (int'(req.release_family) < int'(nf)) && (req.release_slot < rel_count);
        cur_count = count_of(int'(cur_f_reg));
        eligible  = |(caps_of(int'(cur_f_reg)) & need_of(kind_reg));
    end

    // Unwritten words read as all free
    assign word    = rd_valid_reg ? rd_data : '1;
    assign one_hot = {{(SLOTS_PER_FAMILY-1){1'b0}}, 1'b1} << rel_slot_reg;

    qsa_ram #(
        .WIDTH (SLOTS_PER_FAMILY),
        .DEPTH (FAMILIES)
    ) u_free_map (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    qsa_match #(
        .SLOTS (SLOTS_PER_FAMILY)
    ) u_match (
        .free_word (word),
        .count     (cur_count),
        .prio      (prio_reg),
        .eligible  (eligible),
        .found     (found),
        .slot      (slot)
    );

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        cur_f_next    = cur_f_reg;
        kind_next     = kind_reg;
        prio_next     = prio_reg;
        rel_slot_next = rel_slot_reg;
        rd_en         = 1'b0;
        rd_addr       = cur_f_reg;
        wr_en         = 1'b0;
        wr_addr       = cur_f_reg;
        wr_data       = word;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next     = req.queue_kind;
                    prio_next     = req.wanted_priority;
                    rel_slot_next = SW'(req.release_slot);
                    result_next   = '0;
                    if (req.req_type == qsa_pkg::REQ_RELEASE)
                    begin
                        if (rel_ok)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = FW'(req.release_family);
                            cur_f_next = FW'(req.release_family);
                            state_next = S_REL;
                        end
                        else
                        begin
                            done_next          = 1'b1;
                            result_next.status = qsa_pkg::STATUS_BAD_SLOT;
                        end
                    end
                    else if (nf == '0 || need_of(req.queue_kind) == '0)
                    begin
                        done_next          = 1'b1;
                        result_next.status = qsa_pkg::STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = start_f;
                        cur_f_next = start_f;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (found)
                begin
                    wr_en                      = 1'b1;
                    wr_data                    = word & ~({{(SLOTS_PER_FAMILY-1){1'b0}}, 1'b1} << slot);
                    done_next                  = 1'b1;
                    result_next.status         = qsa_pkg::STATUS_OK;
                    result_next.granted_family = 2'(cur_f_reg);
                    result_next.granted_slot   = 6'(slot);
                    state_next                 = S_IDLE;
                end
                else if (cur_f_reg == '0)
                begin
                    done_next          = 1'b1;
                    result_next.status = qsa_pkg::STATUS_NOT_FOUND;
                    state_next         = S_IDLE;
                end
                else
                begin
                    // move to the next lower family
                    cur_f_next = cur_f_reg - FW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = cur_f_reg - FW'(1);
                end
            end

            S_REL:
            begin
                wr_en              = 1'b1;
                wr_data            = word | one_hot;
                done_next          = 1'b1;
                result_next.status = qsa_pkg::STATUS_OK;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            cur_f_reg    <= '0;
            result_reg   <= '0;
            kind_reg     <= '0;
            prio_reg     <= '0;
            rel_slot_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            cur_f_reg    <= cur_f_next;
            result_reg   <= result_next;
            kind_reg     <= kind_next;
            prio_reg     <= prio_next;
            rel_slot_reg <= rel_slot_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    // a result only follows a started or running request
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a request");

    // free map is written back only at the end of a request
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (busy && state_next == S_IDLE))
        else $error("free map write outside a request end");

    // read and write of the free map never share a cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("free map read and write overlap");

    // a found slot is reported as a granted result
    a_grant_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && found) |=> (done && result.status == qsa_pkg::STATUS_OK))
        else $error("grant lost");
`endif

endmodule

>>> tb/queue_slot_allocator_tb.sv
`timescale 1ns / 100ps

module queue_slot_allocator_tb;
    import qsa_pkg::*;

    localparam int NUM_FAM    = DEF_FAMILIES;
    localparam int NUM_SLOTS  = DEF_SLOTS;
    localparam int CLK_PERIOD = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 65;

    // codes outside the defined sets
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam logic [1:0] PRIO_UNKNOWN = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor state
    logic [FAMILY_COUNT_W-1:0] fam_count_r;
    logic [CAPS_W-1:0]         caps_r;
    logic [COUNTS_W-1:0]       counts_r;
    logic [NUM_SLOTS-1:0]      free_map [NUM_FAM];

    result_t     outcome_q [$];
    logic [7:0]  held_q [$];    // {family, slot} of slots we hold
    result_t     want;
    int          errors;
    int          cycle_count;
    bit          idle_on;

    queue_slot_allocator #(
        .FAMILIES         (NUM_FAM),
        .SLOTS_PER_FAMILY (NUM_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, outcome_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic int unsigned families_present();
        return (fam_count_r > NUM_FAM) ? NUM_FAM : fam_count_r;
    endfunction

    function automatic int unsigned queues_in(int unsigned f);
        int unsigned c;
        c = counts_r[COUNT_BITS*f +: COUNT_BITS];
        return (c > NUM_SLOTS) ? NUM_SLOTS : c;
    endfunction

    function automatic logic [1:0] slot_prio(int unsigned cnt, int unsigned s);
        if (cnt == 1)
            return PRIO_NORMAL;
        if (cnt == 2)
            return (s == 0) ? PRIO_NORMAL : PRIO_HIGH;
        if (s == cnt - 1)
            return PRIO_REALTIME;
        return (s < cnt / 2) ? PRIO_NORMAL : PRIO_HIGH;
    endfunction

    function automatic result_t allocate_slot(req_t r);
        result_t            res;
        logic [CAPS_BITS-1:0] need;
        int unsigned        nf;
        int unsigned        f;
        int unsigned        cnt;
        bit                 found;
        res = '0;
        res.status = STATUS_NOT_FOUND;
        nf = families_present();
        if (r.req_type == REQ_RELEASE)
        begin
            if (r.release_family < nf && r.release_slot < queues_in(r.release_family))
            begin
                free_map[r.release_family][r.release_slot] = 1'b1;
                res.status = STATUS_OK;
            end
            else
                res.status = STATUS_BAD_SLOT;
        end
        else
        begin
            case (r.queue_kind)
                KIND_COPY:     need = CAP_TRANSFER;
                KIND_COMPUTE:  need = CAP_COMPUTE;
                KIND_GRAPHICS: need = CAP_GRAPHICS;
                default:       need = '0;
            endcase
            found = 1'b0;
            for (int i = 0; i < nf && !found; i++)
            begin
                f = nf - 1 - i;
                if ((caps_r[CAPS_BITS*f +: CAPS_BITS] & need) == '0)
                    continue;
                cnt = queues_in(f);
                for (int s = 0; s < cnt && !found; s++)
                begin
                    if (free_map[f][s] && slot_prio(cnt, s) == r.wanted_priority)
                    begin
                        free_map[f][s] = 1'b0;
                        res.status = STATUS_OK;
                        res.granted_family = 2'(f);
                        res.granted_slot = 6'(s);
                        found = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    // ---------------- drivers ----------------

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FAMILY_COUNT: fam_count_r = data[FAMILY_COUNT_W-1:0];
            CFG_FAMILY_CAPS:  caps_r = data[CAPS_W-1:0];
            CFG_QUEUE_COUNTS: counts_r = data[COUNTS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry random junk
    task automatic program_config(input logic [FAMILY_COUNT_W-1:0] cnt,
                                  input logic [CAPS_W-1:0] caps,
                                  input logic [COUNTS_W-1:0] counts);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom());
        d[FAMILY_COUNT_W-1:0] = cnt;
        write_reg(CFG_FAMILY_COUNT, d);
        d = CFG_DATA_W'($urandom());
        d[CAPS_W-1:0] = caps;
        write_reg(CFG_FAMILY_CAPS, d);
        write_reg(CFG_QUEUE_COUNTS, counts);
    endtask

    // lower start and wait until every outstanding result is back
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (outcome_q.size() != 0 || busy)
            @(posedge clk);
    endtask

    // start stays high after the transfer; the next call lowers it only for an idle gap, wait_idle always does
    task automatic send_request(input req_t r);
        int      gap;
        result_t res;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        res = allocate_slot(r);
        outcome_q = {outcome_q, res};
        if (r.req_type == REQ_ACQUIRE && res.status == STATUS_OK)
            held_q = {held_q, {res.granted_family, res.granted_slot}};
    endtask

    function automatic req_t acquire_item(logic [1:0] kind, logic [1:0] prio);
        req_t r;
        r = '0;
        r.req_type = REQ_ACQUIRE;
        r.queue_kind = kind;
        r.wanted_priority = prio;
        return r;
    endfunction

    function automatic req_t release_item(logic [1:0] fam, logic [5:0] slot);
        req_t r;
        r = '0;
        r.req_type = REQ_RELEASE;
        r.release_family = fam;
        r.release_slot = slot;
        return r;
    endfunction

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: result with none expected: expected none, actual %h",
                         $time, result);
                errors++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (result.status !== want.status)
                begin
                    $display("%0t: status: expected %0d, actual %0d",
                             $time, want.status, result.status);
                    errors++;
                end
                if (result.granted_family !== want.granted_family)
                begin
                    $display("%0t: granted_family: expected %0d, actual %0d",
                             $time, want.granted_family, result.granted_family);
                    errors++;
                end
                if (result.granted_slot !== want.granted_slot)
                begin
                    $display("%0t: granted_slot: expected %0d, actual %0d",
                             $time, want.granted_slot, result.granted_slot);
                    errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    // registers still at reset: no families at all
    task automatic test_empty_config();
        send_request(acquire_item(KIND_COPY, PRIO_NORMAL));
        send_request(release_item(2'd0, 6'd0));
        wait_idle();
    endtask

    // one kind per family but the last, which has all three; counts 1, 2, 3 and an oversized count
    task automatic test_priorities_and_kinds();
        program_config(3'd4,
                       {CAP_GRAPHICS | CAP_COMPUTE | CAP_TRANSFER, CAP_TRANSFER,
                        CAP_COMPUTE, CAP_GRAPHICS},
                       {7'd127, 7'd3, 7'd2, 7'd1});
        send_request(acquire_item(KIND_GRAPHICS, PRIO_NORMAL));
        send_request(acquire_item(KIND_GRAPHICS, PRIO_REALTIME));
        send_request(acquire_item(KIND_GRAPHICS, PRIO_REALTIME));
        send_request(acquire_item(KIND_COMPUTE, PRIO_HIGH));
        send_request(acquire_item(KIND_COPY, PRIO_REALTIME));
        send_request(acquire_item(KIND_UNKNOWN, PRIO_NORMAL));
        send_request(acquire_item(KIND_GRAPHICS, PRIO_UNKNOWN));
        send_request(release_item(2'd3, 6'd63));
        send_request(release_item(2'd3, 6'd63));   // already free
        send_request(release_item(2'd0, 6'd1));    // beyond count
        send_request(release_item(2'd1, 6'd1));
        send_request(release_item(2'd3, 6'd0));
        send_request(release_item(2'd2, 6'd3));
        wait_idle();
    endtask

    // family count above the number of families, then fewer families
    task automatic test_family_clamp();
        program_config(3'd7, 12'hFFF, {7'd127, 7'd3, 7'd2, 7'd1});
        send_request(acquire_item(KIND_COMPUTE, PRIO_HIGH));
        send_request(release_item(2'd3, 6'd33));
        wait_idle();
        program_config(3'd2, {3'b000, 3'b000, CAP_COMPUTE, CAP_GRAPHICS},
                       {7'd0, 7'd0, 7'd2, 7'd1});
        send_request(release_item(2'd2, 6'd0));
        send_request(acquire_item(KIND_COPY, PRIO_NORMAL));
        wait_idle();
    endtask

    // slots left outside a shrunk count keep their state
    task automatic test_shrink_config();
        send_request(acquire_item(KIND_GRAPHICS, PRIO_NORMAL));
        wait_idle();
        program_config(3'd2, {3'b000, 3'b000, CAP_COMPUTE, CAP_GRAPHICS},
                       {7'd0, 7'd0, 7'd2, 7'd0});
        send_request(release_item(2'd0, 6'd0));
        send_request(acquire_item(KIND_GRAPHICS, PRIO_NORMAL));
        wait_idle();
        program_config(3'd2, {3'b000, 3'b000, CAP_COMPUTE, CAP_GRAPHICS},
                       {7'd0, 7'd0, 7'd2, 7'd1});
        send_request(acquire_item(KIND_GRAPHICS, PRIO_NORMAL));
        send_request(release_item(2'd0, 6'd0));
        send_request(acquire_item(KIND_GRAPHICS, PRIO_NORMAL));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [FAMILY_COUNT_W-1:0] cnt;
        logic [COUNTS_W-1:0]       counts;
        logic [COUNT_BITS-1:0]     c;
        req_t                      r;
        int                        roll;
        int                        k;
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                program_config(3'd7, 12'hFFF, 28'hFFFFFFF);
            else if (p == 1)
                program_config(3'd4, 12'hFFF, {4{7'd1}});
            else
            begin
                roll = $urandom_range(0, 9);
                cnt = (roll == 0) ? 3'd0 : (roll == 1) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(1, 4));
                for (int f = 0; f < NUM_FAM; f++)
                begin
                    roll = $urandom_range(0, 19);
                    if (roll < 3)
                        c = 7'd0;
                    else if (roll < 6)
                        c = 7'($urandom_range(64, 127));
                    else
                        c = 7'($urandom_range(1, 9));
                    counts[COUNT_BITS*f +: COUNT_BITS] = c;
                end
                program_config(cnt, 12'($urandom()), counts);
            end
            idle_on = (p % 3 != 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off until the block has drained
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                roll = $urandom_range(0, 99);
                r = req_t'(13'($urandom_range(0, 8191)));
                if (roll < 50)
                begin
                    r.req_type = REQ_ACQUIRE;
                    r.queue_kind = 2'($urandom_range(0, 2));
                    r.wanted_priority = 2'($urandom_range(0, 2));
                end
                else if (roll < 82 && held_q.size() != 0)
                begin
                    k = $urandom_range(0, held_q.size() - 1);
                    r.req_type = REQ_RELEASE;
                    {r.release_family, r.release_slot} = held_q[k];
                    held_q.delete(k);
                end
                send_request(r);
            end
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fam_count_r = '0;
        caps_r = '0;
        counts_r = '0;
        for (int f = 0; f < NUM_FAM; f++)
            free_map[f] = '1;
        errors = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_config();
        test_priorities_and_kinds();
        test_family_clamp();
        test_shrink_config();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
